// ===== rtl/ps2cre_pkg.sv =====
// Package for the PS/2 command retry engine: op, status and CSR codes,
// protocol byte constants and the result record type.
// Standalone; used by ps2_command_retry_engine_unit.
package ps2cre_pkg;

   // Input item operation codes
   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_RX_BYTE = 2'd1,
      OP_TICK    = 2'd2,
      OP_REFUSED = 2'd3
   } op_type;

   // Completion status codes
   typedef enum logic [2:0] {
      ST_SUCCESS   = 3'd0,
      ST_BUSY      = 3'd1,
      ST_TIMEOUT   = 3'd2,
      ST_DEV_ERROR = 3'd3,
      ST_EXHAUSTED = 3'd4
   } status_type;

   // Register index, taken from paddr[2]
   typedef enum logic [0:0] {
      CSR_TIMEOUT = 1'b0,
      CSR_MAX_ATT = 1'b1
   } csr_idx_type;

   // Result kind
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Protocol bytes
   localparam logic [7:0] ACK_BYTE    = 8'hFA;
   localparam logic [7:0] RESEND_BYTE = 8'hFE;
   localparam logic [7:0] AUX_PREFIX  = 8'hD4;

   // Register widths and reset values
   localparam int TIMEOUT_W = 20;
   localparam int ATT_W     = 4;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd100000;
   localparam logic [ATT_W-1:0]     MAX_ATT_RESET = 4'd3;

   // Result buffer sizing: one input item causes at most four results
   localparam int MAX_RES = 4;
   localparam int RES_CNT_W = 3;

   // One result item
   typedef struct packed {
      logic       kind;
      logic       to_cmd;
      logic [7:0] tx_byte;
      status_type status;
      logic [7:0] device_code;
      logic [7:0] response_data;
      logic       last;
   } res_type;

endpackage

// ===== rtl/ps2_command_retry_engine_unit.sv =====
// Top level of the PS/2 command retry engine: command state, result buffer
// and APB-style register port.
// Depends on ps2cre_pkg.
//
// Latency: the results of an item are presented the cycle after it is accepted.
// Throughput: one item per cycle while items cause at most one result and rsp_stall
// is low; an item that sends a request (start or resend) causes up to four results,
// which leave through the single result register at one per cycle while not stalled,
// so the next item waits until the last buffered result is being taken.
// Reset: synchronous; command goes idle, counters clear, registers return to
// timeout 100000 and max attempts 3.
module ps2_command_retry_engine_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_command_byte,
   input  logic        req_has_payload,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_want_data,
   input  logic        req_second_port,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic        rsp_to_command_port,
   output logic [7:0]  rsp_tx_byte,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_device_code,
   output logic [7:0]  rsp_response_data,
   output logic        rsp_last,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ps2cre_pkg::*;

   // Configuration registers
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [ATT_W-1:0]     max_att_ff, max_att_in;

   // Command state
   logic                 active_ff, active_in;
   logic                 ack_vld_ff, ack_vld_in;
   logic [7:0]           ack_code_ff, ack_code_in;
   logic                 held_vld_ff, held_vld_in;
   logic [7:0]           held_data_ff, held_data_in;
   logic [ATT_W-1:0]     attempt_ff, attempt_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;

   // Saved request
   logic [7:0] sv_cmd_ff, sv_cmd_in;
   logic       sv_has_ff, sv_has_in;
   logic [7:0] sv_pay_ff, sv_pay_in;
   logic       sv_want_ff, sv_want_in;
   logic       sv_aux_ff, sv_aux_in;

   // Result buffer, head at entry 0
   res_type [MAX_RES-1:0] res_ff, res_in;
   logic [RES_CNT_W-1:0]  num_ff, num_in;

   // Per-item decode
   res_type [MAX_RES-1:0] new_res;
   logic [RES_CNT_W-1:0]  new_num;
   logic                  do_send;
   logic                  do_fin;
   status_type            fin_status;
   logic [7:0]            fin_code;
   logic [7:0]            fin_data;

   logic req_acc;
   logic rsp_take;
   logic csr_wr;

   // Handshakes: take an item once the buffer is empty or its last entry leaves
   assign rsp_valid = (num_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = !((num_ff == '0) || ((num_ff == RES_CNT_W'(1)) && rsp_take));
   assign req_acc   = req_valid && !req_stall;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      timeout_in = timeout_ff;
      max_att_in = max_att_ff;
      if (csr_wr) begin
         unique case (csr_idx_type'(csr_paddr[2]))
            CSR_TIMEOUT: timeout_in = csr_pwdata[TIMEOUT_W-1:0];
            CSR_MAX_ATT: max_att_in = csr_pwdata[ATT_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx_type'(csr_paddr[2]))
         CSR_TIMEOUT: csr_prdata = {{(32-TIMEOUT_W){1'b0}}, timeout_ff};
         CSR_MAX_ATT: csr_prdata = {{(32-ATT_W){1'b0}}, max_att_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // Command state update and decision for the accepted item
   always_comb begin
      active_in    = active_ff;
      ack_vld_in   = ack_vld_ff;
      ack_code_in  = ack_code_ff;
      held_vld_in  = held_vld_ff;
      held_data_in = held_data_ff;
      attempt_in   = attempt_ff;
      elapsed_in   = elapsed_ff;
      sv_cmd_in    = sv_cmd_ff;
      sv_has_in    = sv_has_ff;
      sv_pay_in    = sv_pay_ff;
      sv_want_in   = sv_want_ff;
      sv_aux_in    = sv_aux_ff;
      do_send      = 1'b0;
      do_fin       = 1'b0;
      fin_status   = ST_SUCCESS;
      fin_code     = '0;
      fin_data     = '0;
      if (req_acc) begin
         unique case (op_type'(req_op))
            OP_START: begin
               sv_cmd_in  = req_command_byte;
               sv_has_in  = req_has_payload;
               sv_pay_in  = req_payload_byte;
               sv_want_in = req_want_data;
               sv_aux_in  = req_second_port;
               active_in  = 1'b1;
               attempt_in = ATT_W'(1);
               do_send    = 1'b1;
            end
            OP_RX_BYTE: begin
               if (active_ff) begin
                  // classify the byte
                  if (req_rx_byte == ACK_BYTE) begin
                     ack_vld_in  = 1'b1;
                     ack_code_in = req_rx_byte;
                  end else if (req_rx_byte > ACK_BYTE) begin
                     ack_vld_in  = 1'b1;
                     ack_code_in = req_rx_byte;
                     held_vld_in = 1'b0;
                  end else begin
                     held_vld_in  = 1'b1;
                     held_data_in = req_rx_byte;
                  end
                  // decide once an acknowledge or error code is held
                  if (ack_vld_in) begin
                     if (ack_code_in == ACK_BYTE) begin
                        if (!sv_want_ff) begin
                           do_fin = 1'b1;
                        end else if (held_vld_in) begin
                           do_fin   = 1'b1;
                           fin_data = held_data_in;
                        end
                     end else if (ack_code_in == RESEND_BYTE) begin
                        if (attempt_ff < max_att_ff) begin
                           attempt_in = attempt_ff + ATT_W'(1);
                           do_send    = 1'b1;
                        end else begin
                           do_fin     = 1'b1;
                           fin_status = ST_EXHAUSTED;
                        end
                     end else begin
                        do_fin     = 1'b1;
                        fin_status = ST_DEV_ERROR;
                        fin_code   = ack_code_in;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (active_ff) begin
                  elapsed_in = elapsed_ff + TIMEOUT_W'(1);
                  if (elapsed_in >= timeout_ff) begin
                     do_fin     = 1'b1;
                     fin_status = ST_TIMEOUT;
                  end
               end
            end
            OP_REFUSED: begin
               if (active_ff) begin
                  do_fin     = 1'b1;
                  fin_status = ST_BUSY;
               end
            end
            default: ;
         endcase
      end
      // a (re)send starts a fresh attempt
      if (do_send) begin
         ack_vld_in  = 1'b0;
         held_vld_in = 1'b0;
         elapsed_in  = '0;
      end
      if (do_fin) begin
         active_in = 1'b0;
      end
   end

   // Results of the accepted item
   always_comb begin
      new_res = '0;
      new_num = '0;
      if (do_send) begin
         if (sv_aux_in) begin
            new_res[0].to_cmd  = 1'b1;
            new_res[0].tx_byte = AUX_PREFIX;
            new_res[1].tx_byte = sv_cmd_in;
            if (sv_has_in) begin
               new_res[2].to_cmd  = 1'b1;
               new_res[2].tx_byte = AUX_PREFIX;
               new_res[3].tx_byte = sv_pay_in;
               new_num            = RES_CNT_W'(4);
            end else begin
               new_num = RES_CNT_W'(2);
            end
         end else begin
            new_res[0].tx_byte = sv_cmd_in;
            if (sv_has_in) begin
               new_res[1].tx_byte = sv_pay_in;
               new_num            = RES_CNT_W'(2);
            end else begin
               new_num = RES_CNT_W'(1);
            end
         end
      end else if (do_fin) begin
         new_res[0].kind          = KIND_FINISH;
         new_res[0].status        = fin_status;
         new_res[0].device_code   = fin_code;
         new_res[0].response_data = fin_data;
         new_num                  = RES_CNT_W'(1);
      end
      // mark the final result of this item
      for (int i = 0; i < MAX_RES; i++) begin
         new_res[i].last = (RES_CNT_W'(i) == (new_num - RES_CNT_W'(1)));
      end
   end

   // Result buffer: load on accept, else shift out on take
   always_comb begin
      res_in = res_ff;
      num_in = num_ff;
      if (req_acc) begin
         res_in = new_res;
         num_in = new_num;
      end else if (rsp_take) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         res_in[MAX_RES-1] = '0;
         num_in            = num_ff - RES_CNT_W'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         max_att_ff  <= MAX_ATT_RESET;
         active_ff   <= 1'b0;
         ack_vld_ff  <= 1'b0;
         held_vld_ff <= 1'b0;
         attempt_ff  <= '0;
         elapsed_ff  <= '0;
         num_ff      <= '0;
      end else begin
         timeout_ff  <= timeout_in;
         max_att_ff  <= max_att_in;
         active_ff   <= active_in;
         ack_vld_ff  <= ack_vld_in;
         held_vld_ff <= held_vld_in;
         attempt_ff  <= attempt_in;
         elapsed_ff  <= elapsed_in;
         num_ff      <= num_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ack_code_ff  <= ack_code_in;
      held_data_ff <= held_data_in;
      sv_cmd_ff    <= sv_cmd_in;
      sv_has_ff    <= sv_has_in;
      sv_pay_ff    <= sv_pay_in;
      sv_want_ff   <= sv_want_in;
      sv_aux_ff    <= sv_aux_in;
      res_ff       <= res_in;
   end

   // Output fields come from the buffer head
   assign rsp_kind            = res_ff[0].kind;
   assign rsp_to_command_port = res_ff[0].to_cmd;
   assign rsp_tx_byte         = res_ff[0].tx_byte;
   assign rsp_status          = res_ff[0].status;
   assign rsp_device_code     = res_ff[0].device_code;
   assign rsp_response_data   = res_ff[0].response_data;
   assign rsp_last            = res_ff[0].last;

   // Checks
   a_last_is_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (num_ff == RES_CNT_W'(1)))
      else $error("last result shown while more results are buffered");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_op == OP_START)) |=> (rsp_valid && active_ff))
      else $error("accepted start did not open a command with results");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_FINISH)) |-> !active_ff)
      else $error("finish result shown while command still active");

   a_stall_needs_data: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && !(num_ff == RES_CNT_W'(1) && !rsp_stall)))
      else $error("input stalled without pending results");

endmodule
